// ===== rtl/core/dcpp_pkg.sv =====
// shared constants, character codes and the queue item type of the packet parser
// no dependencies

package dcpp_pkg;

  localparam int DIGITS_DEF       = 4;
  localparam int SCROLL_DEPTH_DEF = 16;
  localparam int SHOWN            = 4;
  localparam int CHAR_W           = 8;
  localparam int IDX_W            = 8;
  localparam int CNT_W            = 9;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CH_SYNC  = 8'hFF;
  localparam logic [7:0] CH_RESET = 8'h7E;
  localparam logic [7:0] CH_SET   = 8'h53;
  localparam logic [7:0] CH_BLOCK = 8'h42;
  localparam logic [7:0] CH_ERR   = 8'h45;
  localparam logic [7:0] CH_CMD   = 8'h43;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_TICK  = 3'd1;
  localparam logic [2:0] K_PAIR  = 3'd2;
  localparam logic [2:0] K_SBYTE = 3'd3;
  localparam logic [2:0] K_BBYTE = 3'd4;

  typedef struct packed {
    logic [2:0]       kind;
    logic             rst;
    logic [7:0]       hi;
    logic [7:0]       data;
    logic             wr;
    logic [IDX_W-1:0] idx;
    logic             commit;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

// ===== rtl/core/dcpp_ram.sv =====
// generic single write port ram with registered read
// no dependencies beyond dcpp_pkg defaults

module dcpp_ram
  import dcpp_pkg::*;
#(
  parameter int WIDTH = CHAR_W,
  parameter int DEPTH = 2 * SCROLL_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dcpp_fifo.sv =====
// two entry queue of classified items between parser front and execution back
// depends on dcpp_pkg

module dcpp_fifo
  import dcpp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_item,
  output logic full,
  output logic q_valid,
  output cmd_t q_item,
  input  logic q_ready
);

  cmd_t       buf_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = buf_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= ~wp_r;
      end
      if (do_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/dcpp_front.sv =====
// packet framing front end: tracks sync, length, command and payload index
// and turns every accepted item into a queue command; depends on dcpp_pkg

module dcpp_front
  import dcpp_pkg::*;
#(
  parameter int SCROLL_DEPTH = SCROLL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       q_push,
  output cmd_t       q_item,
  input  logic       q_full
);

  localparam int PW = $clog2(SCROLL_DEPTH + 1);

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_CMD  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [7:0]    code_r, code_nxt;
  logic [PW-1:0] pidx_r, pidx_nxt;
  logic          wr;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign wr       = (pidx_r < PW'(SCROLL_DEPTH));

  always_comb begin
    phase_nxt     = phase_r;
    rem_nxt       = rem_r;
    code_nxt      = code_r;
    pidx_nxt      = pidx_r;
    q_item.kind   = K_NONE;
    q_item.rst    = 1'b0;
    q_item.hi     = '0;
    q_item.data   = in_rx_byte;
    q_item.wr     = 1'b0;
    q_item.idx    = IDX_W'(pidx_r);
    q_item.commit = 1'b0;
    q_item.count  = CNT_W'(pidx_r);
    if (in_op == OP_TICK) begin
      q_item.kind = K_TICK;
    end else begin
      unique case (phase_r)
        PH_SYNC: begin
          if (in_rx_byte == CH_SYNC) begin
            phase_nxt = PH_LEN;
          end else if (in_rx_byte == CH_RESET) begin
            q_item.rst = 1'b1;
          end else begin
            q_item.kind = K_PAIR;
            q_item.hi   = CH_ERR;
          end
        end
        PH_LEN: begin
          rem_nxt   = (in_rx_byte == 8'd0) ? 8'd1 : in_rx_byte;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          code_nxt     = in_rx_byte;
          pidx_nxt     = '0;
          rem_nxt      = rem_r - 8'd1;
          q_item.count = '0;
          if (rem_nxt == 8'd0) begin
            q_item.commit = 1'b1;
            phase_nxt     = PH_SYNC;
            if (in_rx_byte == CH_SET) begin
              q_item.kind = K_SBYTE;
            end else if (in_rx_byte == CH_BLOCK) begin
              q_item.kind = K_BBYTE;
            end else begin
              q_item.kind = K_PAIR;
              q_item.hi   = CH_CMD;
            end
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          q_item.wr = wr;
          if (wr) begin
            pidx_nxt = pidx_r + PW'(1);
          end
          rem_nxt       = rem_r - 8'd1;
          q_item.commit = (rem_nxt == 8'd0);
          q_item.count  = CNT_W'(pidx_nxt);
          if (rem_nxt == 8'd0) begin
            phase_nxt = PH_SYNC;
          end
          if (code_r == CH_SET) begin
            q_item.kind = K_SBYTE;
          end else if (code_r == CH_BLOCK) begin
            q_item.kind = K_BBYTE;
          end else if (rem_nxt == 8'd0) begin
            q_item.kind = K_PAIR;
            q_item.hi   = CH_CMD;
            q_item.data = code_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC;
      rem_r   <= '0;
      code_r  <= '0;
      pidx_r  <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      code_r  <= code_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

endmodule

// ===== rtl/core/dcpp_back.sv =====
// execution back end: display, staging, two-bank scroll store and scroll window
// holds the result register; depends on dcpp_pkg and dcpp_ram

module dcpp_back
  import dcpp_pkg::*;
#(
  parameter int DIGITS       = DIGITS_DEF,
  parameter int SCROLL_DEPTH = SCROLL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_item,
  output logic       q_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_shown_char0,
  output logic [7:0] out_shown_char1,
  output logic [7:0] out_shown_char2,
  output logic [7:0] out_shown_char3,
  output logic       out_scrolling,
  output logic       out_reset_request
);

  localparam int AW = $clog2(SCROLL_DEPTH);
  localparam int EN = 2 ** AW;
  localparam int PW = $clog2(SCROLL_DEPTH + 1);
  localparam int XW = PW + 1;
  localparam int D1 = (DIGITS >= 2) ? 1 : 0;

  function automatic logic [7:0] boot_char(input int i);
    logic [7:0] c;
    case (i) inside
      0:       c = 8'h76;
      1:       c = 8'h31;
      2, 3:    c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  logic [7:0]    disp_r [DIGITS];
  logic [7:0]    disp_nxt [DIGITS];
  logic [7:0]    sstg_r [DIGITS];
  logic [7:0]    sstg_nxt [DIGITS];
  logic [EN-1:0] sel_r, sel_nxt;
  logic [EN-1:0] ld_r, ld_nxt;
  logic [EN-1:0] pend_r, pend_nxt;
  logic          active_r, active_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] len_r, len_nxt;
  logic          rreq_r;
  logic          vld_r;
  logic [7:0]    byp_r;
  logic          take;
  logic          b_wr;
  logic [AW-1:0] widx;
  logic [AW:0]   waddr;
  logic [7:0]    shown [SHOWN];

  assign q_ready = !vld_r || out_ready;
  assign take    = q_valid && q_ready;
  assign widx    = q_item.idx[AW-1:0];
  assign b_wr    = take && (q_item.kind == K_BBYTE) && q_item.wr;
  assign waddr   = {~sel_r[widx], widx};

  always_comb begin
    disp_nxt   = disp_r;
    sstg_nxt   = sstg_r;
    sel_nxt    = sel_r;
    ld_nxt     = ld_r;
    pend_nxt   = pend_r;
    active_nxt = active_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    unique case (q_item.kind)
      K_PAIR: begin
        disp_nxt[0] = q_item.hi;
        if (DIGITS >= 2) begin
          disp_nxt[D1] = q_item.data;
        end
      end
      K_SBYTE: begin
        for (int i = 0; i < DIGITS; i++) begin
          if (q_item.wr && q_item.idx == IDX_W'(i)) begin
            sstg_nxt[i] = q_item.data;
          end
        end
        if (q_item.commit) begin
          for (int i = 0; i < DIGITS; i++) begin
            disp_nxt[i] = (CNT_W'(i) < q_item.count) ? sstg_nxt[i] : CH_SPACE;
          end
        end
      end
      K_BBYTE: begin
        for (int i = 0; i < EN; i++) begin
          if (q_item.wr && q_item.idx == IDX_W'(i)) begin
            pend_nxt[i] = 1'b1;
          end
        end
        if (q_item.commit) begin
          for (int i = 0; i < EN; i++) begin
            if (pend_nxt[i]) begin
              sel_nxt[i] = ~sel_r[i];
              ld_nxt[i]  = 1'b1;
            end
          end
          pend_nxt   = '0;
          len_nxt    = q_item.count[PW-1:0];
          pos_nxt    = '0;
          active_nxt = 1'b1;
        end
      end
      K_TICK: begin
        if (active_r) begin
          pos_nxt = pos_r + PW'(1);
          if ((len_r <= PW'(1)) || (XW'(pos_r) + XW'(2) >= XW'(len_r))) begin
            active_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= 1'b0;
      active_r <= 1'b0;
      pos_r    <= '0;
      len_r    <= '0;
      sel_r    <= '0;
      ld_r     <= '0;
      pend_r   <= '0;
      rreq_r   <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        disp_r[i] <= boot_char(i);
      end
    end else begin
      if (q_ready) begin
        vld_r <= q_valid;
      end
      if (take) begin
        active_r <= active_nxt;
        pos_r    <= pos_nxt;
        len_r    <= len_nxt;
        sel_r    <= sel_nxt;
        ld_r     <= ld_nxt;
        pend_r   <= pend_nxt;
        rreq_r   <= q_item.rst;
        disp_r   <= disp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sstg_r <= sstg_nxt;
      byp_r  <= q_item.data;
    end
  end

  for (genvar k = 0; k < SHOWN; k++) begin : g_win
    logic [XW-1:0] ra;
    logic [XW-1:0] oa;
    logic [AW:0]   raddr;
    logic [7:0]    rdata;
    logic [7:0]    win;
    logic [7:0]    dch;
    logic          hit_r;

    assign ra    = XW'(pos_nxt) + XW'(k);
    assign raddr = {sel_nxt[ra[AW-1:0]], ra[AW-1:0]};
    assign oa    = XW'(pos_r) + XW'(k);

    dcpp_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(2 * EN)
    ) u_ram (
      .clk  (clk),
      .we   (b_wr),
      .waddr(waddr),
      .wdata(q_item.data),
      .re   (take),
      .raddr(raddr),
      .rdata(rdata)
    );

    always_ff @(posedge clk) begin
      if (take) begin
        hit_r <= b_wr && (waddr == raddr);
      end
    end

    assign win = ((oa < XW'(SCROLL_DEPTH)) && ld_r[oa[AW-1:0]]) ?
                 (hit_r ? byp_r : rdata) : 8'h00;

    if (k < DIGITS) begin : g_disp
      assign dch = disp_r[k];
    end else begin : g_nodisp
      assign dch = 8'h00;
    end

    assign shown[k] = active_r ? win : dch;
  end

  assign out_valid         = vld_r;
  assign out_shown_char0   = shown[0];
  assign out_shown_char1   = shown[1];
  assign out_shown_char2   = shown[2];
  assign out_shown_char3   = shown[3];
  assign out_scrolling     = active_r;
  assign out_reset_request = rreq_r;

endmodule

// ===== rtl/core/display_command_packet_parser_top.sv =====
// display command packet parser: framing front end, two entry queue, execution back end
// result valid the cycle after the item leaves the queue, which registers every accepted item
// one item per cycle while out_ready is high; the queue lets front and back stall on their own
// synchronous active-low reset clears parser, queue and scroll state and restores the boot
// characters; the scroll store needs no clearing pass (per-entry loaded bits)
// depends on dcpp_pkg, dcpp_front, dcpp_fifo, dcpp_back, dcpp_ram

module display_command_packet_parser_top
  import dcpp_pkg::*;
#(
  parameter int DIGITS       = DIGITS_DEF,
  parameter int SCROLL_DEPTH = SCROLL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_op,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_shown_char0,
  output logic [7:0] out_shown_char1,
  output logic [7:0] out_shown_char2,
  output logic [7:0] out_shown_char3,
  output logic       out_scrolling,
  output logic       out_reset_request
);

  logic push;
  cmd_t push_item;
  logic full;
  logic q_valid;
  cmd_t q_item;
  logic q_ready;
  logic pop;

  assign pop = q_valid && q_ready;

  dcpp_front #(
    .SCROLL_DEPTH(SCROLL_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .in_rx_byte(in_rx_byte),
    .q_push    (push),
    .q_item    (push_item),
    .q_full    (full)
  );

  dcpp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .full     (full),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  dcpp_back #(
    .DIGITS      (DIGITS),
    .SCROLL_DEPTH(SCROLL_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_ready          (q_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_shown_char0  (out_shown_char0),
    .out_shown_char1  (out_shown_char1),
    .out_shown_char2  (out_shown_char2),
    .out_shown_char3  (out_shown_char3),
    .out_scrolling    (out_scrolling),
    .out_reset_request(out_reset_request)
  );

  a_scroll_only_tick_or_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_item.kind != K_TICK && q_item.kind != K_BBYTE
    |=> out_scrolling == $past(out_scrolling))
    else $error("scrolling changed on an item that is neither tick nor load");

  a_load_starts_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_item.kind == K_BBYTE && q_item.commit |=> out_scrolling && out_valid)
    else $error("completed scroll load did not start scrolling");

  a_reset_request_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && out_reset_request == $past(q_item.rst))
    else $error("reset request does not match its item");

endmodule

// ===== tb/sv/tb_display_command_packet_parser_top.sv =====
// testbench for display_command_packet_parser_top: directed and random byte/tick items,
// a local predictor of the parser and scroll window, random idling on both channels
// depends on dcpp_pkg and display_command_packet_parser_top
`timescale 1ns / 100ps

module tb_display_command_packet_parser_top;
  import dcpp_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 7;
  localparam int DIGITS       = DIGITS_DEF;
  localparam int SCROLL_DEPTH = SCROLL_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1650;
  localparam int CALM_ITEMS   = 150;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CH_OTHER = 8'h51;

  typedef enum logic [1:0] {SEEK_SYNC, TAKE_LEN, TAKE_CMD, TAKE_DATA} parse_phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic       wait_drain;
  } rx_item_t;

  typedef struct packed {
    logic [SHOWN-1:0][7:0] chars;
    logic                  scrolling;
    logic                  reset_req;
  } shown_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_op = OP_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_shown_char0;
  logic [7:0] out_shown_char1;
  logic [7:0] out_shown_char2;
  logic [7:0] out_shown_char3;
  logic       out_scrolling;
  logic       out_reset_request;

  // predictor state, "v100" at boot
  logic [7:0]   disp_chars [DIGITS] = '{8'h76, 8'h31, 8'h30, 8'h30};
  logic [7:0]   scroll_mem [SCROLL_DEPTH] = '{default: 8'h00};
  logic [7:0]   staging [SCROLL_DEPTH] = '{default: 8'h00};
  logic         scroll_on = 1'b0;
  int unsigned  scroll_pos = 0;
  int unsigned  scroll_len = 0;
  parse_phase_t phase = SEEK_SYNC;
  logic [7:0]   left_count = 8'h00;
  logic [7:0]   cmd_code = 8'h00;
  int unsigned  pay_count = 0;

  rx_item_t pending_q [$];
  shown_t   shown_q [$];
  logic     in_taken = 1'b0;
  bit       drain_next = 1'b0;
  int       mismatches = 0;
  int       items_taken = 0;

  int  send_gap = 0;
  int  send_mode_left = 0;
  bit  send_bursty = 1'b0;
  int  recv_stall = 0;
  int  recv_mode_left = 0;
  bit  recv_bursty = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  display_command_packet_parser_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shown_char0   (out_shown_char0),
    .out_shown_char1   (out_shown_char1),
    .out_shown_char2   (out_shown_char2),
    .out_shown_char3   (out_shown_char3),
    .out_scrolling     (out_scrolling),
    .out_reset_request (out_reset_request)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void finish_packet();
    if (cmd_code == CH_SET) begin
      for (int i = 0; i < DIGITS; i++) begin
        disp_chars[i] = (i < pay_count) ? staging[i] : CH_SPACE;
      end
    end else if (cmd_code == CH_BLOCK) begin
      for (int i = 0; i < SCROLL_DEPTH; i++) begin
        if (i < pay_count) scroll_mem[i] = staging[i];
      end
      scroll_len = pay_count;
      scroll_pos = 0;
      scroll_on  = 1'b1;
    end else begin
      disp_chars[0] = CH_CMD;
      disp_chars[1] = cmd_code;
    end
    phase = SEEK_SYNC;
  endfunction

  function automatic shown_t apply_item(logic op, logic [7:0] b);
    shown_t      r;
    int unsigned idx;
    r = '0;
    if (op == OP_TICK) begin
      if (scroll_on) begin
        scroll_pos++;
        if (scroll_len <= 1 || scroll_pos >= scroll_len - 1) scroll_on = 1'b0;
      end
    end else begin
      case (phase)
        SEEK_SYNC: begin
          if (b == CH_SYNC) begin
            phase = TAKE_LEN;
          end else if (b == CH_RESET) begin
            r.reset_req = 1'b1;
          end else begin
            disp_chars[0] = CH_ERR;
            disp_chars[1] = b;
          end
        end
        TAKE_LEN: begin
          left_count = (b == 8'h00) ? 8'h01 : b;
          phase = TAKE_CMD;
        end
        TAKE_CMD: begin
          cmd_code = b;
          pay_count = 0;
          left_count = left_count - 8'h01;
          if (left_count == 8'h00) finish_packet();
          else phase = TAKE_DATA;
        end
        default: begin
          if (pay_count < SCROLL_DEPTH) begin
            staging[pay_count] = b;
            pay_count++;
          end
          left_count = left_count - 8'h01;
          if (left_count == 8'h00) finish_packet();
        end
      endcase
    end
    for (int k = 0; k < SHOWN; k++) begin
      if (scroll_on) begin
        idx = scroll_pos + k;
        r.chars[k] = (idx < SCROLL_DEPTH) ? scroll_mem[idx] : 8'h00;
      end else begin
        r.chars[k] = (k < DIGITS) ? disp_chars[k] : 8'h00;
      end
    end
    r.scrolling = scroll_on;
    return r;
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 15))
      0, 1: return CH_SYNC;
      2: return CH_RESET;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    pending_q.push_back('{op: OP_BYTE, rx_byte: b, wait_drain: drain_next});
    drain_next = 1'b0;
  endtask

  task automatic queue_tick();
    pending_q.push_back('{op: OP_TICK, rx_byte: 8'($urandom), wait_drain: drain_next});
    drain_next = 1'b0;
  endtask

  // honest length counts command plus payload, otherwise a random length breaks framing
  task automatic queue_packet(input logic [7:0] code, input int unsigned n_pay,
                              input bit honest, input bit mix_ticks);
    int unsigned len;
    len = honest ? n_pay + 1 : $urandom_range(0, 20);
    queue_byte(CH_SYNC);
    queue_byte(8'(len));
    queue_byte(code);
    for (int unsigned i = 0; i < n_pay; i++) begin
      if (mix_ticks && $urandom_range(0, 19) == 0) queue_tick();
      queue_byte(any_byte());
    end
  endtask

  // input side: one item offered at a time, held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].wait_drain && shown_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_valid   <= 1'b1;
        in_op      <= pending_q[0].op;
        in_rx_byte <= pending_q[0].rx_byte;
        pending_q.pop_front();
        if (send_mode_left == 0) begin
          send_bursty = $urandom_range(0, 1);
          send_mode_left = $urandom_range(30, 200);
        end else begin
          send_mode_left = send_mode_left - 1;
        end
        if (send_bursty && pending_q.size() >= CALM_ITEMS && $urandom_range(0, 3) == 0)
          send_gap = $urandom_range(1, 13);
      end
    end
  end

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && items_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall = recv_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_mode_left == 0) begin
          recv_bursty = $urandom_range(0, 1);
          recv_mode_left = $urandom_range(40, 300);
        end else begin
          recv_mode_left = recv_mode_left - 1;
        end
        if (recv_bursty && pending_q.size() >= CALM_ITEMS && $urandom_range(0, 3) == 0)
          recv_stall = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    shown_t want;
    shown_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = '{chars: {out_shown_char3, out_shown_char2, out_shown_char1, out_shown_char0},
                scrolling: out_scrolling, reset_req: out_reset_request};
        if (shown_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: chars %h scrolling %b reset_request %b",
                     got.chars, got.scrolling, got.reset_req);
        end else begin
          want = shown_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: chars %h/%h scrolling %b/%b reset_request %b/%b (exp/act)",
                       want.chars, got.chars, want.scrolling, got.scrolling,
                       want.reset_req, got.reset_req);
          end
        end
      end
      if (in_valid && in_ready) begin
        shown_q.push_back(apply_item(in_op, in_rx_byte));
        items_taken++;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned n;
    int          goal;
    logic [7:0]  code;
    bit          drain_marked;

    // directed items
    queue_tick();
    queue_byte(CH_RESET);
    queue_byte(8'h00);
    queue_byte(CH_SYNC);
    queue_byte(8'h00);
    queue_byte(CH_SET);
    queue_packet(CH_SET, 2, 1'b1, 1'b0);
    queue_packet(CH_OTHER, 1, 1'b1, 1'b0);
    queue_packet(CH_BLOCK, 4, 1'b1, 1'b0);
    repeat (5) queue_tick();

    // random items, opened by one packet at the largest length
    queue_packet(CH_SET, 254, 1'b1, 1'b0);
    goal = pending_q.size() + RANDOM_ITEMS - 257;
    drain_marked = 1'b0;
    while (pending_q.size() < goal) begin
      if (!drain_marked && pending_q.size() >= goal / 2) begin
        drain_next = 1'b1;
        drain_marked = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 28) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        queue_packet(CH_SET, n, $urandom_range(0, 19) != 0, 1'b1);
      end else if (sel < 55) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 22) : $urandom_range(0, 16);
        queue_packet(CH_BLOCK, n, $urandom_range(0, 19) != 0, 1'b1);
        repeat ($urandom_range(0, 18)) queue_tick();
      end else if (sel < 65) begin
        code = 8'($urandom);
        if (code == CH_SET || code == CH_BLOCK) code = CH_CMD;
        queue_packet(code, $urandom_range(0, 3), $urandom_range(0, 19) != 0, 1'b1);
      end else if (sel < 75) begin
        repeat ($urandom_range(1, 4)) queue_tick();
      end else begin
        queue_byte(any_byte());
      end
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || shown_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && shown_q.size() == 0) begin
      $display("[display_command_packet_parser_top] OK");
    end else begin
      $display("[display_command_packet_parser_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[display_command_packet_parser_top] ERROR");
    $finish;
  end

endmodule

// ===== display_command_packet_parser_top.f =====
rtl/core/dcpp_pkg.sv
rtl/core/dcpp_ram.sv
rtl/core/dcpp_fifo.sv
rtl/core/dcpp_front.sv
rtl/core/dcpp_back.sv
rtl/core/display_command_packet_parser_top.sv
tb/sv/tb_display_command_packet_parser_top.sv
